// ----- design/skct_pkg.sv -----
// ----------------------------------------------------------------------------
// skct_pkg
// Shared types and constants of the sorted key cache table.
// ----------------------------------------------------------------------------
package skct_pkg;

   localparam int CAPACITY_DEF  = 2048;
   localparam int SWEEP_MIN_DEF = 1024;

   localparam logic [1:0] CMD_ACCESS   = 2'd0;
   localparam logic [1:0] CMD_REMOVE   = 2'd1;
   localparam logic [1:0] CMD_CLEAR    = 2'd2;
   localparam logic [1:0] CMD_RESERVED = 2'd3;

   localparam logic [3:0] ST_HIT       = 4'd0;
   localparam logic [3:0] ST_MISMATCH  = 4'd1;
   localparam logic [3:0] ST_INSERTED  = 4'd2;
   localparam logic [3:0] ST_LOAD_FAIL = 4'd3;
   localparam logic [3:0] ST_FULL      = 4'd4;
   localparam logic [3:0] ST_REMOVED   = 4'd5;
   localparam logic [3:0] ST_NOT_FOUND = 4'd6;
   localparam logic [3:0] ST_INVALID   = 4'd7;
   localparam logic [3:0] ST_CLEARED   = 4'd8;

   localparam logic REG_BALANCE_LIMIT = 1'b0;
   localparam logic REG_CHECK_POINT   = 1'b1;

   // Operation the row of cells performs.
   typedef enum logic [2:0] {
      OP_HOLD,
      OP_INSERT,
      OP_REMOVE,
      OP_MARK,
      OP_UNREF
   } cell_op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_SWEEP,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [31:0] key;
      logic [7:0]  etype;
      logic        refd;
   } entry_type;

endpackage

// ----- design/skct_if.sv -----
// ----------------------------------------------------------------------------
// skct_req_if / skct_rsp_if / skct_csr_if
// Valid/ready channels of the sorted key cache table.
// ----------------------------------------------------------------------------
interface skct_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [31:0] key;
   logic [7:0]  entry_type;
   logic        load_ok;
   modport source (output valid, command, key, entry_type, load_ok, input ready);
   modport sink   (input valid, command, key, entry_type, load_ok, output ready);
endinterface

interface skct_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  status;
   logic [10:0] position;
   logic [11:0] entry_count;
   logic        swept;
   modport source (output valid, status, position, entry_count, swept, input ready);
   modport sink   (input valid, status, position, entry_count, swept, output ready);
endinterface

interface skct_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/skct_cell.sv -----
// ----------------------------------------------------------------------------
// skct_cell
// One table slot: holds an entry and takes its neighbours' entries on shifts.
// ----------------------------------------------------------------------------
module skct_cell (
   input  logic                 clock,
   input  skct_pkg::cell_op_type op,
   input  logic                 at_or_above,   // slot takes part in the shift
   input  logic                 at_target,
   input  logic                 lower_above,   // left neighbour shifts too
   input  skct_pkg::entry_type  new_entry,
   input  skct_pkg::entry_type  left_entry,
   input  skct_pkg::entry_type  right_entry,
   output skct_pkg::entry_type  entry_out
);
   skct_pkg::entry_type entry_ff, entry_in;

   always_comb begin
      entry_in = entry_ff;
      unique case (op)
         skct_pkg::OP_INSERT: begin
            if (at_target) entry_in = new_entry;
            else if (at_or_above && lower_above) entry_in = left_entry;
         end
         skct_pkg::OP_REMOVE: begin
            if (at_or_above) entry_in = right_entry;
         end
         skct_pkg::OP_MARK: begin
            if (at_target) entry_in.refd = 1'b1;
         end
         skct_pkg::OP_UNREF: begin
            entry_in.refd = 1'b0;
         end
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_out = entry_ff;
endmodule

// ----- design/sorted_key_cache_table.sv -----
// ----------------------------------------------------------------------------
// sorted_key_cache_table
// Sorted key table with a reference-bit eviction sweep, built as a row of cells.
// ----------------------------------------------------------------------------
// Use: commands arrive as beats on the req channel (access, remove, clear),
// and each yields exactly one beat on the rsp channel. Registers are to be
// written through the csr channel only while the block is idle; the block
// itself does not enforce this, and csr_ready is always high. The table is a
// row of CAPACITY cells, every cell comparing its key with the request key
// in parallel, so the search is combinational. Inserts and removes shift the
// upper part of the row by one place. Without a sweep a request passes the
// decide state and raises the response beat on entering the done state; the
// next request is taken only after that response beat has been taken.
// A sweep removes the lowest unreferenced entry in each cycle by shifting
// everything above it down one place, then a final step clears the
// reference bits.
// One item is in flight at a time; req_ready is low until its response beat
// has been taken. A stalled receiver simply holds the response register.
// Reset clears the entry count, the access counter and the registers to their
// defaults; the cell contents stay undefined and are never read unwritten.
// ----------------------------------------------------------------------------
module sorted_key_cache_table #(
   parameter int SWEEP_MIN = skct_pkg::SWEEP_MIN_DEF
) (
   input  logic  clock,
   input  logic  reset,
   skct_req_if.sink   req,
   skct_rsp_if.source rsp,
   skct_csr_if.sink   csr
);
   localparam int CAPACITY = skct_pkg::CAPACITY_DEF;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);

   skct_pkg::state_type state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [31:0]    acc_ff, acc_in;
   logic [11:0]    bal_ff;
   logic [31:0]    chk_ff;
   logic [1:0]     cmd_ff;
   logic [31:0]    key_ff;
   logic [7:0]     ty_ff;
   logic           load_ff;
   logic [3:0]     status_ff, status_in;
   logic [10:0]    pos_ff, pos_in;
   logic           swept_ff, swept_in;
   logic           rsp_valid_ff;
   logic [CW-1:0]  keep_cnt_ff, keep_cnt_in;

   skct_pkg::cell_op_type op;
   skct_pkg::entry_type   ent [CAPACITY];
   skct_pkg::entry_type   new_entry;
   logic [CAPACITY-1:0]   vld, less, eq, tgt, drop_pre, shift;
   logic [IW-1:0]         lb;
   logic [7:0]            hit_type;
   logic                  hit, any_drop, drop_seen;

   assign new_entry = '{key: key_ff, etype: ty_ff, refd: 1'b1};

   // Per-cell comparisons; the row is sorted so less is a thermometer code.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         vld[i]  = CW'(i) < count_ff;
         less[i] = vld[i] && (ent[i].key < key_ff);
         eq[i]   = vld[i] && (ent[i].key == key_ff);
      end
   end

   // The first slot not below the request key is where less ends, so this
   // vector is one-hot whenever the row has room at that place.
   always_comb begin
      tgt[0] = !less[0];
      for (int i = 1; i < CAPACITY; i++) tgt[i] = !less[i] && less[i-1];
   end

   always_comb begin
      lb       = '0;
      hit_type = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (tgt[i]) lb = lb | IW'(i);
         if (eq[i])  hit_type = hit_type | ent[i].etype;
      end
   end
   assign hit = |eq;

   // Every slot at or above the lowest unreferenced live entry shifts down
   // during a sweep step.
   always_comb begin
      drop_seen = 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
         drop_seen   = drop_seen || ((CW'(i) < keep_cnt_ff) && !ent[i].refd);
         drop_pre[i] = drop_seen;
      end
   end
   assign any_drop = drop_pre[CAPACITY-1];
   assign shift    = (state_ff == skct_pkg::S_SWEEP) ? drop_pre : ~less;

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         skct_pkg::entry_type l_e, r_e;
         logic l_a;
         if (g == 0) begin : g_l
            assign l_e = new_entry;
            assign l_a = 1'b0;
         end else begin : g_l
            assign l_e = ent[g-1];
            assign l_a = shift[g-1];
         end
         if (g == CAPACITY-1) begin : g_r
            assign r_e = ent[g];
         end else begin : g_r
            assign r_e = ent[g+1];
         end
         skct_cell u_cell (
            .clock       (clock),
            .op          (op),
            .at_or_above (shift[g]),
            .at_target   (tgt[g]),
            .lower_above (l_a),
            .new_entry   (new_entry),
            .left_entry  (l_e),
            .right_entry (r_e),
            .entry_out   (ent[g])
         );
      end
   endgenerate

   assign req.ready = (state_ff == skct_pkg::S_IDLE);
   assign csr.ready = 1'b1;

   logic [31:0] acc_inc;
   logic [CW-1:0] count_new;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      acc_in      = acc_ff;
      status_in   = status_ff;
      pos_in      = pos_ff;
      swept_in    = swept_ff;
      keep_cnt_in = keep_cnt_ff;
      op          = skct_pkg::OP_HOLD;
      acc_inc     = acc_ff + 32'd1;
      count_new   = count_ff;
      unique case (state_ff)
         skct_pkg::S_IDLE: begin
            if (req.valid) state_in = skct_pkg::S_DECIDE;
         end
         skct_pkg::S_DECIDE: begin
            state_in = skct_pkg::S_DONE;
            swept_in = 1'b0;
            pos_in   = '0;
            priority if (cmd_ff == skct_pkg::CMD_CLEAR) begin
               count_in  = '0;
               acc_in    = '0;
               status_in = skct_pkg::ST_CLEARED;
            end else if (cmd_ff == skct_pkg::CMD_RESERVED || key_ff == 32'd0) begin
               status_in = skct_pkg::ST_INVALID;
            end else if (cmd_ff == skct_pkg::CMD_REMOVE) begin
               if (hit) begin
                  op        = skct_pkg::OP_REMOVE;
                  count_in  = count_ff - CW'(1);
                  pos_in    = 11'(lb);
                  status_in = skct_pkg::ST_REMOVED;
               end else begin
                  status_in = skct_pkg::ST_NOT_FOUND;
               end
            end else if (hit || (count_ff < CW'(CAPACITY) && load_ff)) begin
               pos_in = 11'(lb);
               if (hit) begin
                  if (hit_type == ty_ff) begin
                     op        = skct_pkg::OP_MARK;
                     status_in = skct_pkg::ST_HIT;
                  end else begin
                     status_in = skct_pkg::ST_MISMATCH;
                  end
               end else begin
                  op        = skct_pkg::OP_INSERT;
                  count_new = count_ff + CW'(1);
                  count_in  = count_new;
                  status_in = skct_pkg::ST_INSERTED;
               end
               if (32'(count_new) > 32'(bal_ff)) begin
                  acc_in = acc_inc;
                  if (acc_inc > chk_ff) begin
                     acc_in = '0;
                     if (32'(count_new) >= 32'(SWEEP_MIN)) begin
                        swept_in = 1'b1;
                        state_in = skct_pkg::S_SWEEP;
                        keep_cnt_in = count_new;
                     end
                  end
               end
            end else if (count_ff >= CW'(CAPACITY)) begin
               status_in = skct_pkg::ST_FULL;
            end else begin
               status_in = skct_pkg::ST_LOAD_FAIL;
            end
         end
         skct_pkg::S_SWEEP: begin
            // The hit or insert has settled by now. Each step drops the
            // lowest unreferenced live entry; the last step clears the
            // reference bits of the survivors.
            if (any_drop) begin
               op = skct_pkg::OP_REMOVE;
               keep_cnt_in = keep_cnt_ff - CW'(1);
            end else begin
               op       = skct_pkg::OP_UNREF;
               count_in = keep_cnt_ff;
               state_in = skct_pkg::S_DONE;
            end
         end
         skct_pkg::S_DONE: begin
            if (rsp_valid_ff && rsp.ready) state_in = skct_pkg::S_IDLE;
         end
         default: state_in = skct_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= skct_pkg::S_IDLE;
         count_ff     <= '0;
         acc_ff       <= '0;
         bal_ff       <= 12'd484;
         chk_ff       <= 32'd484;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         acc_ff   <= acc_in;
         if (csr.valid) begin
            if (csr.index == skct_pkg::REG_BALANCE_LIMIT) bal_ff <= csr.data[11:0];
            else chk_ff <= csr.data;
         end
         if (state_ff != skct_pkg::S_DONE && state_in == skct_pkg::S_DONE)
            rsp_valid_ff <= 1'b1;
         else if (rsp.ready)
            rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         cmd_ff  <= req.command;
         key_ff  <= req.key;
         ty_ff   <= req.entry_type;
         load_ff <= req.load_ok;
      end
      status_ff   <= status_in;
      pos_ff      <= pos_in;
      swept_ff    <= swept_in;
      keep_cnt_ff <= keep_cnt_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = status_ff;
   assign rsp.position    = pos_ff;
   assign rsp.entry_count = 12'(count_ff);
   assign rsp.swept       = swept_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != skct_pkg::S_IDLE) |-> !req.ready)
      else $error("request taken while busy");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count beyond capacity");
   a_rsp_only_done: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (state_ff == skct_pkg::S_DONE))
      else $error("response outside done state");
endmodule
